### rtl/core/srlm_pkg.sv
// Shared types, constants and helpers for the line matcher
package srlm_pkg;

	localparam int MAX_STATES = 64;
	localparam int MAX_LINE   = 1024;
	localparam int TAB_AW     = $clog2(MAX_STATES);
	localparam int CNT_W      = TAB_AW + 1;
	localparam int LINE_AW    = $clog2(MAX_LINE);
	localparam int LEN_W      = LINE_AW + 1;

	// entry types
	localparam logic [1:0] TY_CHAR  = 2'd0;
	localparam logic [1:0] TY_EOL   = 2'd1;
	localparam logic [1:0] TY_RANGE = 2'd2;
	localparam logic [1:0] TY_DOT   = 2'd3;

	// parser phases
	localparam logic [3:0] PH_START  = 4'd0;
	localparam logic [3:0] PH_NORMAL = 4'd1;
	localparam logic [3:0] PH_ESC    = 4'd2;
	localparam logic [3:0] PH_LO     = 4'd3;
	localparam logic [3:0] PH_SEP    = 4'd4;
	localparam logic [3:0] PH_HI     = 4'd5;
	localparam logic [3:0] PH_CLOSE  = 4'd6;
	localparam logic [3:0] PH_DOLLAR = 4'd7;
	localparam logic [3:0] PH_SKIP   = 4'd8;

	// compile status codes
	localparam logic [3:0] ER_NONE    = 4'd0;
	localparam logic [3:0] ER_CARET   = 4'd1;
	localparam logic [3:0] ER_DOLLAR  = 4'd2;
	localparam logic [3:0] ER_QUANT   = 4'd3;
	localparam logic [3:0] ER_RLO     = 4'd4;
	localparam logic [3:0] ER_RSEP    = 4'd5;
	localparam logic [3:0] ER_RHI     = 4'd6;
	localparam logic [3:0] ER_RORDER  = 4'd7;
	localparam logic [3:0] ER_BRACKET = 4'd8;
	localparam logic [3:0] ER_ESCAPE  = 4'd9;
	localparam logic [3:0] ER_LONG    = 4'd10;

	// special bytes
	localparam logic [7:0] CH_CARET  = 8'h5E;
	localparam logic [7:0] CH_DOLLAR = 8'h24;
	localparam logic [7:0] CH_QUEST  = 8'h3F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_DOT    = 8'h2E;
	localparam logic [7:0] CH_LBR    = 8'h5B;
	localparam logic [7:0] CH_RBR    = 8'h5D;
	localparam logic [7:0] CH_DASH   = 8'h2D;
	localparam logic [7:0] CH_BSL    = 8'h5C;
	localparam logic [7:0] CH_NL     = 8'h0A;

	typedef struct packed {
		logic       rep;
		logic       opt;
		logic [1:0] ty;
		logic [7:0] hi;
		logic [7:0] lo;
	} ent_t;

	typedef struct packed {
		logic pat_acc;
		logic line_acc;
		logic out_pat;
		logic scan_start;
		logic scan_eval;
		logic out_line;
	} cmd_t;

	typedef struct packed {
		logic trivial;
		logic fin;
	} stat_t;

	// does one line byte satisfy one entry
	function automatic logic byte_fits(logic [7:0] c, ent_t e);
		logic r;
		unique case (e.ty)
			TY_CHAR:  r = (c == e.lo);
			TY_EOL:   r = (c == CH_NL);
			TY_RANGE: r = (c >= e.lo) && (c <= e.hi);
			default:  r = (c != CH_NL);
		endcase
		return r;
	endfunction

endpackage

### rtl/core/srlm_if.sv
// Request and result channel interfaces
interface srlm_in_if;
	logic       valid;
	logic       ready;
	logic       kind;
	logic [7:0] data_byte;
	logic       is_last;
	modport source (output valid, kind, data_byte, is_last, input ready);
	modport sink (input valid, kind, data_byte, is_last, output ready);
endinterface

interface srlm_out_if;
	logic        valid;
	logic        ready;
	logic        result_kind;
	logic [3:0]  parse_status;
	logic        line_matched;
	logic        line_selected;
	logic [31:0] line_number;
	logic [10:0] found_offset;
	logic [10:0] found_length;
	logic        line_truncated;
	modport source (output valid, result_kind, parse_status, line_matched, line_selected,
		line_number, found_offset, found_length, line_truncated, input ready);
	modport sink (input valid, result_kind, parse_status, line_matched, line_selected,
		line_number, found_offset, found_length, line_truncated, output ready);
endinterface

### rtl/core/srlm_ram.sv
// Generic single write, single registered read RAM
module srlm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

### rtl/core/srlm_ctrl.sv
// Sequencing controller: request acceptance, scan steps, result hand-off
module srlm_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	input  logic           in_kind,
	input  logic           in_last,
	output logic           in_ready,
	input  logic           out_ready,
	output logic           out_valid,
	input  srlm_pkg::stat_t stat,
	output srlm_pkg::cmd_t  cmd
);
	import srlm_pkg::*;

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_RD    = 3'd2;
	localparam logic [2:0] ST_EV    = 3'd3;
	localparam logic [2:0] ST_DONE  = 3'd4;

	logic [2:0] state_q;
	logic       out_valid_q;
	logic       out_free;
	logic       acc;

	// handshake
	assign out_free  = !out_valid_q || out_ready;
	assign in_ready  = (state_q == ST_IDLE) && out_free;
	assign acc       = in_valid && in_ready;
	assign out_valid = out_valid_q;

	// commands to the datapath
	always_comb begin
		cmd            = '0;
		cmd.pat_acc    = acc && !in_kind;
		cmd.line_acc   = acc && in_kind;
		cmd.out_pat    = acc && !in_kind && in_last;
		cmd.scan_start = (state_q == ST_START);
		cmd.scan_eval  = (state_q == ST_EV);
		cmd.out_line   = (state_q == ST_DONE) && out_free;
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE:  if (acc && in_kind && in_last) state_q <= ST_START;
				ST_START: state_q <= stat.trivial ? ST_DONE : ST_RD;
				ST_RD:    state_q <= ST_EV;
				ST_EV:    state_q <= stat.fin ? ST_DONE : ST_RD;
				ST_DONE:  if (out_free) state_q <= ST_IDLE;
				default:  state_q <= ST_IDLE;
			endcase
		end
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_pat || cmd.out_line) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end
endmodule

### rtl/core/srlm_dpath.sv
// Datapath: pattern compiler, line store, scan unit and result register
module srlm_dpath (
	input  logic            clk,
	input  logic            arst_n,
	input  srlm_pkg::cmd_t  cmd,
	output srlm_pkg::stat_t stat,
	input  logic [7:0]      data_byte,
	input  logic            is_last,
	input  logic            cfg_we,
	input  logic            cfg_wdata,
	output logic            result_kind,
	output logic [3:0]      parse_status,
	output logic            line_matched,
	output logic            line_selected,
	output logic [31:0]     line_number,
	output logic [10:0]     found_offset,
	output logic [10:0]     found_length,
	output logic            line_truncated
);
	import srlm_pkg::*;

	// compiler state
	logic [3:0]       ph_q, ph_n;
	logic [3:0]       err_q, err_n;
	logic [CNT_W-1:0] ec_q, ec_n;
	logic             anc_q, anc_n;
	logic [7:0]       plo_q, plo_n, phi_q, phi_n;
	ent_t             last_q, last_n, ent0_q, ent0_n;
	logic             add_req;
	ent_t             add_word;
	logic             twe;
	logic [TAB_AW-1:0] twaddr;
	ent_t             twdata;
	ent_t             tab_rd;
	logic [19:0]      tab_rd_raw;

	// line state
	logic [LEN_W-1:0] llen_q;
	logic             ovf_q;
	logic [31:0]      lcnt_q;
	logic             inv_q;
	logic [7:0]       line_rd;
	logic             lwe;

	// scan state
	logic [LEN_W-1:0] s_q, n_q, jump_q;
	logic [CNT_W-1:0] i_q;
	logic             seen_q;
	logic             match_q;
	logic [LEN_W-1:0] foff_q, flen_q;
	logic [LEN_W:0]   pos;

	// pattern compiler next state
	always_comb begin
		ph_n     = ph_q;
		err_n    = err_q;
		ec_n     = ec_q;
		anc_n    = anc_q;
		plo_n    = plo_q;
		phi_n    = phi_q;
		last_n   = last_q;
		ent0_n   = ent0_q;
		add_req  = 1'b0;
		add_word = '0;
		twe      = 1'b0;
		twaddr   = '0;
		twdata   = '0;
		if (ph_n == PH_START) begin
			ec_n  = '0;
			anc_n = 1'b0;
			err_n = ER_NONE;
			ph_n  = PH_NORMAL;
		end
		unique case (ph_n)
			PH_NORMAL: begin
				priority case (data_byte)
					CH_CARET: begin
						if (ph_q != PH_START) begin
							err_n = ER_CARET;
							ph_n  = PH_SKIP;
						end else begin
							anc_n = 1'b1;
						end
					end
					CH_DOLLAR: begin
						add_req     = 1'b1;
						add_word.ty = TY_EOL;
						ph_n        = PH_DOLLAR;
					end
					CH_QUEST, CH_STAR: begin
						if (ec_n == '0) begin
							err_n = ER_QUANT;
							ph_n  = PH_SKIP;
						end else begin
							twe    = 1'b1;
							twaddr = TAB_AW'(ec_n - 1'b1);
							twdata = last_q;
							twdata.opt = 1'b1;
							if (data_byte == CH_STAR) twdata.rep = 1'b1;
							last_n = twdata;
							if (ec_n == CNT_W'(1)) ent0_n = twdata;
						end
					end
					CH_LBR: ph_n = PH_LO;
					CH_RBR: begin
						err_n = ER_BRACKET;
						ph_n  = PH_SKIP;
					end
					CH_DOT: begin
						add_req     = 1'b1;
						add_word.ty = TY_DOT;
					end
					CH_BSL: ph_n = PH_ESC;
					default: begin
						add_req     = 1'b1;
						add_word.ty = TY_CHAR;
						add_word.lo = data_byte;
						add_word.hi = data_byte;
					end
				endcase
			end
			PH_ESC: begin
				ph_n        = PH_NORMAL;
				add_req     = 1'b1;
				add_word.ty = TY_CHAR;
				add_word.lo = data_byte;
				add_word.hi = data_byte;
			end
			PH_LO: begin
				if (data_byte == CH_RBR) begin
					err_n = ER_RLO;
					ph_n  = PH_SKIP;
				end else begin
					plo_n = data_byte;
					ph_n  = PH_SEP;
				end
			end
			PH_SEP: begin
				if (data_byte != CH_DASH) begin
					err_n = ER_RSEP;
					ph_n  = PH_SKIP;
				end else begin
					ph_n = PH_HI;
				end
			end
			PH_HI: begin
				if (data_byte == CH_RBR) begin
					err_n = ER_RHI;
					ph_n  = PH_SKIP;
				end else begin
					phi_n = data_byte;
					ph_n  = PH_CLOSE;
				end
			end
			PH_CLOSE: begin
				if (data_byte != CH_RBR) begin
					err_n = ER_BRACKET;
					ph_n  = PH_SKIP;
				end else if (phi_q < plo_q) begin
					err_n = ER_RORDER;
					ph_n  = PH_SKIP;
				end else begin
					ph_n        = PH_NORMAL;
					add_req     = 1'b1;
					add_word.ty = TY_RANGE;
					add_word.lo = plo_q;
					add_word.hi = phi_q;
				end
			end
			PH_DOLLAR: begin
				err_n = ER_DOLLAR;
				ph_n  = PH_SKIP;
			end
			default: ;
		endcase
		// append an entry, or report a full table
		if (add_req) begin
			if (ec_n >= CNT_W'(MAX_STATES)) begin
				err_n = ER_LONG;
				ph_n  = PH_SKIP;
			end else begin
				twe    = 1'b1;
				twaddr = TAB_AW'(ec_n);
				twdata = add_word;
				last_n = add_word;
				if (ec_n == '0) ent0_n = add_word;
				ec_n   = ec_n + 1'b1;
			end
		end
		// pattern ending inside an escape or a range
		if (is_last) begin
			priority case (ph_n)
				PH_ESC:   err_n = ER_ESCAPE;
				PH_LO:    err_n = ER_RLO;
				PH_SEP:   err_n = ER_RSEP;
				PH_HI:    err_n = ER_RHI;
				PH_CLOSE: err_n = ER_BRACKET;
				default:  ;
			endcase
			ph_n = PH_START;
		end
	end

	// compiler registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ph_q  <= PH_START;
			err_q <= ER_NONE;
			ec_q  <= '0;
			anc_q <= 1'b0;
		end else if (cmd.pat_acc) begin
			ph_q  <= ph_n;
			err_q <= err_n;
			ec_q  <= ec_n;
			anc_q <= anc_n;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.pat_acc) begin
			plo_q  <= plo_n;
			phi_q  <= phi_n;
			last_q <= last_n;
			ent0_q <= ent0_n;
		end
	end

	// pattern table
	srlm_ram #(.WIDTH(20), .DEPTH(MAX_STATES)) u_tab (
		.clk   (clk),
		.we    (cmd.pat_acc && twe),
		.waddr (twaddr),
		.wdata (twdata),
		.raddr (i_q[TAB_AW-1:0]),
		.rdata (tab_rd_raw)
	);
	assign tab_rd = ent_t'(tab_rd_raw);

	// line store
	assign lwe = cmd.line_acc && (llen_q < LEN_W'(MAX_LINE));
	assign pos = {1'b0, s_q} + {1'b0, n_q};

	srlm_ram #(.WIDTH(8), .DEPTH(MAX_LINE)) u_line (
		.clk   (clk),
		.we    (lwe),
		.waddr (llen_q[LINE_AW-1:0]),
		.wdata (data_byte),
		.raddr (pos[LINE_AW-1:0]),
		.rdata (line_rd)
	);

	// line length, overflow, line count and invert register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			llen_q <= '0;
			ovf_q  <= 1'b0;
			lcnt_q <= '0;
			inv_q  <= 1'b0;
		end else begin
			if (cfg_we) inv_q <= cfg_wdata;
			if (cmd.out_line) begin
				llen_q <= '0;
				ovf_q  <= 1'b0;
			end else if (cmd.line_acc) begin
				if (lwe) llen_q <= llen_q + 1'b1;
				else ovf_q <= 1'b1;
			end
			if (cmd.line_acc && is_last) lcnt_q <= lcnt_q + 1'b1;
		end
	end

	// one scan step on the registered byte and entry
	logic             fit_i, fit_0, miss, cont, hit;
	logic             seen_n;
	logic [LEN_W-1:0] jump_n, n_n, jstep;
	logic [CNT_W-1:0] i_n;
	logic [LEN_W:0]   pos_n, s_next;

	always_comb begin
		fit_i  = byte_fits(line_rd, tab_rd);
		fit_0  = byte_fits(line_rd, ent0_q);
		seen_n = seen_q;
		jump_n = jump_q;
		if ((jump_q == LEN_W'(1)) && (i_q != '0) && !seen_q && fit_0) begin
			seen_n = 1'b1;
			jump_n = n_q;
		end
		i_n  = i_q;
		n_n  = n_q;
		miss = 1'b0;
		if (fit_i) begin
			if (!tab_rd.rep) i_n = i_q + 1'b1;
			n_n = n_q + 1'b1;
		end else if (tab_rd.opt) begin
			i_n = i_q + 1'b1;
		end else begin
			miss = 1'b1;
		end
		pos_n  = {1'b0, s_q} + {1'b0, n_n};
		cont   = !miss && (pos_n < {1'b0, llen_q}) && (i_n < ec_q);
		hit    = !miss && !cont && (i_n == ec_q);
		jstep  = (jump_n == '0) ? LEN_W'(1) : jump_n;
		s_next = {1'b0, s_q} + {1'b0, jstep};
	end

	assign stat.trivial = !((ph_q == PH_START) && (err_q == ER_NONE)) || (ec_q == '0);
	assign stat.fin     = hit || (!cont && (anc_q || (s_next >= {1'b0, llen_q})));

	// scan registers
	always_ff @(posedge clk) begin
		if (cmd.scan_start) begin
			s_q     <= '0;
			n_q     <= '0;
			i_q     <= '0;
			jump_q  <= LEN_W'(1);
			seen_q  <= 1'b0;
			match_q <= (ph_q == PH_START) && (err_q == ER_NONE) && (ec_q == '0);
			foff_q  <= '0;
			flen_q  <= '0;
		end else if (cmd.scan_eval) begin
			if (cont) begin
				i_q    <= i_n;
				n_q    <= n_n;
				seen_q <= seen_n;
				jump_q <= jump_n;
			end else if (hit) begin
				match_q <= 1'b1;
				foff_q  <= s_q;
				flen_q  <= n_n;
			end else if (!stat.fin) begin
				s_q    <= s_next[LEN_W-1:0];
				n_q    <= '0;
				i_q    <= '0;
				jump_q <= LEN_W'(1);
				seen_q <= 1'b0;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (cmd.out_pat) begin
			result_kind    <= 1'b0;
			parse_status   <= err_n;
			line_matched   <= 1'b0;
			line_selected  <= 1'b0;
			line_number    <= '0;
			found_offset   <= '0;
			found_length   <= '0;
			line_truncated <= 1'b0;
		end else if (cmd.out_line) begin
			result_kind    <= 1'b1;
			parse_status   <= ER_NONE;
			line_matched   <= match_q;
			line_selected  <= match_q ^ inv_q;
			line_number    <= lcnt_q;
			found_offset   <= 11'(foff_q);
			found_length   <= 11'(flen_q);
			line_truncated <= ovf_q;
		end
	end
endmodule

### rtl/core/simple_regex_line_matcher.sv
// Top level of the line matcher: controller, datapath and assertions
// Pattern bytes and non-final line bytes are taken while the controller is idle and no
// result is stalled; a final pattern byte gives its status in the following cycle.
// A final line byte starts a scan: a setup state, then scan steps of a read and an evaluate
// state each (registered line store and pattern table reads), then hand-off, steps bounded by restarts.
// Reset clears the compiler, line length, line count and invert register; stores need no clearing.
module simple_regex_line_matcher (
	input logic         clk,
	input logic         arst_n,
	srlm_in_if.sink     item,
	srlm_out_if.source  result,
	input logic         cfg_we,
	input logic         cfg_wdata
);
	import srlm_pkg::*;

	cmd_t  cmd;
	stat_t stat;

	// sequencing
	srlm_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (item.valid),
		.in_kind   (item.kind),
		.in_last   (item.is_last),
		.in_ready  (item.ready),
		.out_ready (result.ready),
		.out_valid (result.valid),
		.stat      (stat),
		.cmd       (cmd)
	);

	// storage and compute
	srlm_dpath u_dpath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.stat           (stat),
		.data_byte      (item.data_byte),
		.is_last        (item.is_last),
		.cfg_we         (cfg_we),
		.cfg_wdata      (cfg_wdata),
		.result_kind    (result.result_kind),
		.parse_status   (result.parse_status),
		.line_matched   (result.line_matched),
		.line_selected  (result.line_selected),
		.line_number    (result.line_number),
		.found_offset   (result.found_offset),
		.found_length   (result.found_length),
		.line_truncated (result.line_truncated)
	);

	// no request taken while a result is stalled
	a_stall_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !(item.valid && item.ready))
		else $error("request accepted while result stalled");

	// no request taken during a scan step
	a_scan_busy: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.scan_eval |-> !item.ready)
		else $error("request accepted during scan");

	// compile status appears right after the final pattern byte
	a_pat_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_pat |=> (result.valid && !result.result_kind))
		else $error("compile status missing");
endmodule
